// ===== design/lfc_pkg.sv =====
// ----------------------------------------------------------------------------
// lfc_pkg: shared types and constants of the line FIR convolution
// Window geometry, arithmetic widths, register indexes and the job record
// that passes from the front pipeline through the queue to the back end.
// ----------------------------------------------------------------------------
package lfc_pkg;

    // Window geometry
    localparam int RADIUS = 3;
    localparam int TAPS   = 2 * RADIUS + 1;
    localparam int HIST   = 2 * RADIUS;

    // Field widths
    localparam int SAMPLE_W = 16;
    localparam int POS_W    = 16;

    // Arithmetic widths
    localparam int PROD_W  = 2 * SAMPLE_W;
    localparam int NPAIR   = (TAPS + 1) / 2;
    localparam int PSUM_W  = PROD_W + 1;
    localparam int ACC_W   = PSUM_W + $clog2(NPAIR) + 1;
    localparam int FRAC_W  = 15;

    // Result counting: at most RADIUS flush zeros plus one regular result
    localparam int FLUSH_W = $clog2(RADIUS + 1);
    localparam int IDX_W   = $clog2(RADIUS + 1);
    localparam int TOTAL_W = $clog2(RADIUS + 2);

    // Result queue
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Configuration port
    localparam int CFG_IDX_W  = 4;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] CFG_LINE_LENGTH = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_COEF_0      = CFG_IDX_W'(1);

    // Reset values of the registers
    localparam logic [POS_W-1:0]    LINE_LENGTH_RST = POS_W'(64);
    localparam logic [SAMPLE_W-1:0] COEF_CENTER_RST = SAMPLE_W'(32767);

    typedef logic signed [SAMPLE_W-1:0] t_sample;
    typedef logic [POS_W-1:0]           t_pos;
    typedef t_sample [TAPS-1:0]         t_coef_set;

    // One accepted sample, reduced to the results it causes
    typedef struct packed {
        logic               has_first;   // regular result at column - RADIUS
        logic               do_fir;      // regular result carries the filter sum
        logic [TOTAL_W-1:0] total;       // number of results for this sample
        t_pos               first_pos;
        t_pos               flush_pos;   // first position of the zero border run
        t_sample            value;
    } t_job;

endpackage

// ===== design/lfc_pix_if.sv =====
// ----------------------------------------------------------------------------
// lfc_pix_if: sample request channel
// Valid/ready handshake carrying one signed pixel per request.
// ----------------------------------------------------------------------------
interface lfc_pix_if;
    import lfc_pkg::*;

    logic    valid;
    logic    ready;
    t_sample pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);

endinterface

// ===== design/lfc_res_if.sv =====
// ----------------------------------------------------------------------------
// lfc_res_if: result request channel
// Valid/ready handshake carrying filtered value, column position and run end.
// ----------------------------------------------------------------------------
interface lfc_res_if;
    import lfc_pkg::*;

    logic    valid;
    logic    ready;
    t_sample filtered;
    t_pos    position;
    logic    run_end;

    modport source (output valid, output filtered, output position, output run_end,
                    input ready);
    modport sink   (input valid, input filtered, input position, input run_end,
                    output ready);

endinterface

// ===== design/lfc_front.sv =====
// ----------------------------------------------------------------------------
// lfc_front: sample intake, classification and tap arithmetic
// Tracks the column, shifts the window, decides which results a sample
// causes and computes the rounded, saturated tap sum over three stages.
// ----------------------------------------------------------------------------
module lfc_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lfc_pkg::t_pos     i_line_length,
    input  lfc_pkg::t_coef_set i_coef,
    lfc_pix_if.sink           i_pix,
    input  logic              i_q_full,
    output logic              o_job_valid,
    output lfc_pkg::t_job     o_job
);
    import lfc_pkg::*;

    logic                     en;
    logic                     take;
    t_pos                     le;
    logic [POS_W:0]           col_inc;
    logic                     last;
    logic [POS_W-1:0]         flush_room;
    t_job                     job0;
    t_job                     job2_done;
    logic signed [PROD_W-1:0] prod [TAPS];
    logic signed [PSUM_W-1:0] psum [NPAIR];
    logic signed [ACC_W-1:0]  acc;
    logic signed [ACC_W-1:0]  quot;
    t_sample                  sat;

    t_pos                     r_column;
    t_sample                  r_window [HIST];
    logic                     r_v1;
    logic                     r_v2;
    logic                     r_v3;
    t_job                     r_job1;
    t_job                     r_job2;
    t_job                     r_job3;
    logic signed [PROD_W-1:0] r_prod [TAPS];
    logic signed [PSUM_W-1:0] r_psum [NPAIR];

    // Stall the whole pipe only when a finished job cannot enter the queue
    assign o_job_valid = r_v3 && (r_job3.total != '0);
    assign en          = !(o_job_valid && i_q_full);
    assign i_pix.ready = en;
    assign take        = i_pix.valid && en;
    assign o_job       = r_job3;

    // Classify the sample against the column and the line length
    always_comb begin
        le         = (i_line_length == '0) ? POS_W'(1) : i_line_length;
        col_inc    = {1'b0, r_column} + (POS_W+1)'(1);
        last       = col_inc >= {1'b0, le};
        job0       = '0;
        job0.has_first = r_column >= POS_W'(RADIUS);
        job0.do_fir    = (r_column >= POS_W'(2 * RADIUS)) && (r_column < le);
        job0.first_pos = r_column - POS_W'(RADIUS);
        job0.flush_pos = job0.has_first ? r_column - POS_W'(RADIUS - 1) : '0;
        flush_room     = le - job0.flush_pos;
        job0.total     = TOTAL_W'(job0.has_first);
        if (last && (le > job0.flush_pos)) begin
            job0.total = TOTAL_W'(job0.has_first) + TOTAL_W'(flush_room[FLUSH_W-1:0]);
        end
    end

    // Multiply each tap, oldest sample on tap zero, incoming pixel on the last
    always_comb begin
        for (int k = 0; k < TAPS; k++) begin
            if (k < HIST) begin
                prod[k] = r_window[k] * $signed(i_coef[k]);
            end else begin
                prod[k] = i_pix.pixel * $signed(i_coef[k]);
            end
        end
    end

    // Pairwise partial sums
    always_comb begin
        for (int j = 0; j < NPAIR; j++) begin
            if (2 * j + 1 < TAPS) begin
                psum[j] = PSUM_W'(r_prod[2*j]) + PSUM_W'(r_prod[2*j+1]);
            end else begin
                psum[j] = PSUM_W'(r_prod[2*j]);
            end
        end
    end

    // Final sum, round half up, saturate
    always_comb begin
        acc = ACC_W'(1) <<< (FRAC_W - 1);
        for (int j = 0; j < NPAIR; j++) begin
            acc = acc + ACC_W'(r_psum[j]);
        end
        quot = acc >>> FRAC_W;
        if (quot > ACC_W'(32767)) begin
            sat = 16'sh7FFF;
        end else if (quot < -ACC_W'(32768)) begin
            sat = 16'sh8000;
        end else begin
            sat = t_sample'(quot[SAMPLE_W-1:0]);
        end
    end

    // Attach the filter value to the job entering the last stage
    always_comb begin
        job2_done       = r_job2;
        job2_done.value = r_job2.do_fir ? sat : '0;
    end

    // Advance column and window on each accepted request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_column <= '0;
            for (int k = 0; k < HIST; k++) begin
                r_window[k] <= '0;
            end
        end else if (take) begin
            r_column <= last ? '0 : col_inc[POS_W-1:0];
            for (int k = 0; k < HIST - 1; k++) begin
                r_window[k] <= r_window[k+1];
            end
            r_window[HIST-1] <= i_pix.pixel;
        end
    end

    // Stage valids
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else if (en) begin
            r_v1 <= take;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
        end
    end

    // Stage payloads
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_job1 <= job0;
            r_job2 <= r_job1;
            r_job3 <= job2_done;
            for (int k = 0; k < TAPS; k++) begin
                r_prod[k] <= prod[k];
            end
            for (int j = 0; j < NPAIR; j++) begin
                r_psum[j] <= psum[j];
            end
        end
    end

endmodule

// ===== design/lfc_queue.sv =====
// ----------------------------------------------------------------------------
// lfc_queue: job queue between front and back
// Small first-in first-out store of job records with a full flag.
// ----------------------------------------------------------------------------
module lfc_queue (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  lfc_pkg::t_job i_job,
    input  logic          i_pop,
    output logic          o_full,
    output logic          o_head_valid,
    output lfc_pkg::t_job o_head
);
    import lfc_pkg::*;

    t_job              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr;
    logic [QPTR_W-1:0] r_rd;
    logic [QCNT_W-1:0] r_cnt;

    assign o_full       = r_cnt == QCNT_W'(QDEPTH);
    assign o_head_valid = r_cnt != '0;
    assign o_head       = r_mem[r_rd];

    // Store pushed jobs
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    // Move pointers and count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd <= r_rd + QPTR_W'(1);
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + QCNT_W'(1);
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - QCNT_W'(1);
            end
        end
    end

endmodule

// ===== design/lfc_back.sv =====
// ----------------------------------------------------------------------------
// lfc_back: result sequencer and output register
// Expands each job into its regular result and zero border run, one
// result per cycle while the output is accepted, and marks the last one of each job.
// ----------------------------------------------------------------------------
module lfc_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_head_valid,
    input  lfc_pkg::t_job i_head,
    output logic          o_pop,
    lfc_res_if.source     o_res
);
    import lfc_pkg::*;

    logic             load;
    logic             is_first;
    logic             is_last;
    logic [IDX_W-1:0] off;
    t_pos             pos;
    t_sample          val;

    logic             r_valid;
    logic [IDX_W-1:0] r_idx;
    t_sample          r_filtered;
    t_pos             r_position;
    logic             r_run_end;

    assign o_res.valid    = r_valid;
    assign o_res.filtered = r_filtered;
    assign o_res.position = r_position;
    assign o_res.run_end  = r_run_end;

    // Pick the result for the current slot of the head job
    always_comb begin
        load     = i_head_valid && (!r_valid || o_res.ready);
        is_first = i_head.has_first && (r_idx == '0);
        off      = r_idx - IDX_W'(i_head.has_first);
        pos      = is_first ? i_head.first_pos : i_head.flush_pos + POS_W'(off);
        val      = is_first ? i_head.value : '0;
        is_last  = (TOTAL_W'(r_idx) + TOTAL_W'(1)) == i_head.total;
        o_pop    = load && is_last;
    end

    // Hold or advance the output register and the slot counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= '0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_idx   <= is_last ? '0 : r_idx + IDX_W'(1);
            end else if (o_res.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_filtered <= val;
            r_position <= pos;
            r_run_end  <= is_last;
        end
    end

endmodule

// ===== design/line_fir_convolution_top.sv =====
// An accepted request passes the front stages, the job queue and the output register.
// Throughput: one sample per cycle while the queue has room; the back end gives one
//   result per cycle while o_res is ready; a line end yields up to RADIUS+1 results.
// The four-entry job queue absorbs those runs while the front keeps accepting.
// Reset (synchronous, active low) clears column, window and pipe, and loads
//   line length 64 and a unit center tap.
// ----------------------------------------------------------------------------
// line_fir_convolution_top: horizontal FIR filter along image lines
// Configuration registers, front pipeline, job queue and result back end.
// ----------------------------------------------------------------------------
module line_fir_convolution_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lfc_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [lfc_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    lfc_pix_if.sink                          i_pix,
    lfc_res_if.source                        o_res
);
    import lfc_pkg::*;

    t_pos      r_line_length;
    t_coef_set r_coef;

    logic q_push;
    logic q_pop;
    logic q_full;
    logic job_valid;
    t_job job;
    logic head_valid;
    t_job head;

    // Write configuration registers; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_length <= LINE_LENGTH_RST;
            for (int k = 0; k < TAPS; k++) begin
                r_coef[k] <= (k == RADIUS) ? COEF_CENTER_RST : '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_idx == CFG_LINE_LENGTH) begin
                r_line_length <= i_cfg_data[POS_W-1:0];
            end
            for (int k = 0; k < TAPS; k++) begin
                if (i_cfg_idx == CFG_COEF_0 + CFG_IDX_W'(k)) begin
                    r_coef[k] <= i_cfg_data[SAMPLE_W-1:0];
                end
            end
        end
    end

    assign q_push = job_valid && !q_full;

    lfc_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_line_length (r_line_length),
        .i_coef        (r_coef),
        .i_pix         (i_pix),
        .i_q_full      (q_full),
        .o_job_valid   (job_valid),
        .o_job         (job)
    );

    lfc_queue u_queue (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (q_push),
        .i_job        (job),
        .i_pop        (q_pop),
        .o_full       (q_full),
        .o_head_valid (head_valid),
        .o_head       (head)
    );

    lfc_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head_valid (head_valid),
        .i_head       (head),
        .o_pop        (q_pop),
        .o_res        (o_res)
    );

`ifndef SYNTH
    // The front drops intake only because the queue is full
    a_ready_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_pix.ready |-> q_full)
        else $error("intake stalled while queue has room");

    // A job leaves the queue only when its last result is loaded
    a_pop_marks_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |=> (o_res.valid && o_res.run_end))
        else $error("job popped without a run end result");

    // Never pop an empty queue
    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_pop |-> head_valid)
        else $error("pop from empty job queue");
`endif

endmodule
